@@ src/i2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to text formatter
// Sizes of the value, the digit shift register and the character buffer,
// the mode and register codes, the state type and the hex digit helper.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_PAD     = 32;

  // decimal digits of the largest VALUE_WIDTH-bit value (1233/4096 ~ log10 2)
  localparam int BCD_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int DIG_W      = 4 * BCD_DIGITS;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;

  // longest text per mode: digit positions, separators, sign
  localparam int DEC_POS = (MAX_PAD > BCD_DIGITS) ? MAX_PAD : BCD_DIGITS;
  localparam int HEX_POS = (MAX_PAD > HEX_DIGITS) ? MAX_PAD : HEX_DIGITS;
  localparam int BIN_POS = (MAX_PAD > VALUE_WIDTH) ? MAX_PAD : VALUE_WIDTH;
  localparam int DEC_LEN = DEC_POS + (DEC_POS - 1) / 3 + 1;
  localparam int HEX_LEN = HEX_POS + (HEX_POS - 1) / 4 + 1;
  localparam int BIN_LEN = BIN_POS + (BIN_POS - 1) / 4;
  localparam int DH_LEN  = (DEC_LEN > HEX_LEN) ? DEC_LEN : HEX_LEN;
  localparam int BUF_DEPTH = (DH_LEN > BIN_LEN) ? DH_LEN : BIN_LEN;

  localparam int PTR_W = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // base_mode codes
  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_LHEX = 2'd1;
  localparam logic [1:0] MODE_UHEX = 2'd2;
  localparam logic [1:0] MODE_BIN  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_CHAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_CHAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_PLUS = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_GEN,
    ST_SIGN,
    ST_PRIME,
    ST_EMIT
  } fmt_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      hex_char = CH_ZERO + d8;
    end else begin
      hex_char = (upper ? CH_UP_A : CH_LOW_A) + d8 - 8'd10;
    end
  endfunction

endpackage

@@ src/i2a_dabble.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_dabble: bit-serial binary to bcd converter
// Shift-and-add-3, one value bit per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [i2a_pkg::VALUE_WIDTH-1:0] value,
  output logic [i2a_pkg::DIG_W-1:0]       bcd,
  output logic                            done
);
  import i2a_pkg::*;

  logic [VALUE_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [DIG_W-1:0]       adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      bcd   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      bcd   <= {adj[DIG_W-2:0], shreg[VALUE_WIDTH-1]};
    end
  end

endmodule

@@ src/i2a_charbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_charbuf: text buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2a_charbuf (
  input  logic                      clk,
  input  logic                      we,
  input  logic [i2a_pkg::IDX_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [i2a_pkg::IDX_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import i2a_pkg::*;

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: signed integer to ascii text
// Formats one value in decimal, hex or binary with optional fill padding,
// digit grouping and sign, and streams the text out one character per beat.
// ----------------------------------------------------------------------------
//
//   channel  signals                       beat content
//   -------  ----------------------------  ----------------------------------
//   in       in_valid, in_ready, number    one value to format
//   out      out_valid, out_ready,         one character, most significant
//            char_code, last_char          first, last_char on the final one
//   cfg      cfg_we, cfg_index, cfg_data   register write, no wait
//
// flow: a nonzero decimal value first passes the bit-serial bcd converter
//   (one bit a cycle); each character is then written once to the buffer,
//   which has one write port and one read port, and read back in order
// reset: synchronous, clears control, pointers and settings; buffer contents
//   are not cleared, every entry is written before it is read
// stalls: out_ready low holds the output register and the read pointer;
//   the next value is taken while the last character still waits
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [i2a_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2a_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                number,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        char_code,
  output logic                              last_char
);
  import i2a_pkg::*;

  // configuration registers
  logic [1:0] base_mode;
  logic [7:0] fill_char;
  logic [5:0] min_digits;
  logic [7:0] group_char;
  logic       force_plus;

  fmt_state_t state, state_next;

  // datapath registers
  logic [DIG_W-1:0] digs;      // digits still to emit, least significant first
  logic [5:0]       rem;       // digit positions still owed to the minimum width
  logic [2:0]       th;        // positions in the current group
  logic [PTR_W-1:0] wptr;      // next write goes below this address
  logic [PTR_W-1:0] raddr;     // read pointer during emission
  logic             zero_r;
  logic             neg_r;

  // input decode
  logic [VALUE_WIDTH-1:0] raw;
  logic                   is_bin;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [5:0]             pad_in;
  logic                   accept;

  // generation
  logic             grp_en;
  logic [2:0]       gsize;
  logic             sep_now;
  logic [7:0]       digit_ch;
  logic [7:0]       gen_ch;
  logic [DIG_W-1:0] digs_shift;
  logic [5:0]       rem_dec;
  logic             gen_done;

  // buffer and converter hookup
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic             dab_start;
  logic [DIG_W-1:0] dab_bcd;
  logic             dab_done;

  // emission
  logic             out_load;
  logic             emit_last;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode  <= MODE_DEC;
      fill_char  <= '0;
      min_digits <= '0;
      group_char <= '0;
      force_plus <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_MODE:  base_mode  <= cfg_data[1:0];
        REG_FILL_CHAR:  fill_char  <= cfg_data;
        REG_MIN_DIGITS: min_digits <= cfg_data[5:0];
        REG_GROUP_CHAR: group_char <= cfg_data;
        REG_FORCE_PLUS: force_plus <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input decode: sign, magnitude, pad count
  // --------------------------------------------------------------------------
  always_comb begin
    raw    = number[VALUE_WIDTH-1:0];
    is_bin = (base_mode == MODE_BIN);
    // binary shows the raw pattern, most negative value wraps to itself
    neg_in = !is_bin && raw[VALUE_WIDTH-1];
    mag_in = neg_in ? (~raw + 1'b1) : raw;
    if (fill_char == 8'd0) begin
      pad_in = '0;
    end else if (min_digits == 6'd0 || min_digits > 6'(MAX_PAD)) begin
      pad_in = 6'(MAX_PAD);
    end else begin
      pad_in = min_digits;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign dab_start = accept && (base_mode == MODE_DEC) && (mag_in != '0);

  // --------------------------------------------------------------------------
  // character generation, one buffer write per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    grp_en  = (group_char != 8'd0);
    gsize   = (base_mode == MODE_DEC) ? 3'd3 : 3'd4;
    sep_now = grp_en && (th == gsize);
    unique case (base_mode)
      MODE_DEC:  digit_ch = CH_ZERO + {4'b0000, digs[3:0]};
      MODE_LHEX: digit_ch = hex_char(digs[3:0], 1'b0);
      MODE_UHEX: digit_ch = hex_char(digs[3:0], 1'b1);
      MODE_BIN:  digit_ch = CH_ZERO + {7'b0000000, digs[0]};
      default:   digit_ch = CH_ZERO;
    endcase
    priority if (zero_r) begin
      gen_ch = CH_ZERO;
    end else if (sep_now) begin
      gen_ch = group_char;
    end else if (digs != '0) begin
      gen_ch = digit_ch;
    end else begin
      gen_ch = fill_char;   // value used up, padding
    end
    digs_shift = is_bin ? (digs >> 1) : (digs >> 4);
    rem_dec    = (rem != 6'd0) ? rem - 6'd1 : 6'd0;
    gen_done   = zero_r || (!sep_now && (digs_shift == '0) && (rem_dec == 6'd0));
  end

  // --------------------------------------------------------------------------
  // control: next state and buffer port
  // --------------------------------------------------------------------------
  assign out_load  = !out_valid || out_ready;
  assign emit_last = (raddr == PTR_W'(BUF_DEPTH - 1));

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wdata  = gen_ch;
    mem_waddr  = IDX_W'(wptr - 1'b1);
    mem_raddr  = raddr[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = dab_start ? ST_CONV : ST_GEN;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_next = ST_GEN;
        end
      end
      ST_GEN: begin
        mem_we = (wptr != '0);
        if (gen_done) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        mem_wdata  = neg_r ? CH_MINUS : CH_PLUS;
        mem_we     = (wptr != '0) && !is_bin && (neg_r || force_plus);
        state_next = ST_PRIME;
      end
      ST_PRIME: begin
        // first character sits at the write pointer
        mem_raddr  = wptr[IDX_W-1:0];
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (emit_last) begin
            state_next = ST_IDLE;
          end else begin
            mem_raddr = IDX_W'(raddr + 1'b1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= PTR_W'(BUF_DEPTH);
      raddr <= '0;
      th    <= '0;
      rem   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wptr <= PTR_W'(BUF_DEPTH);
            th   <= '0;
            rem  <= pad_in;
          end
        end
        ST_GEN: begin
          if (wptr != '0) begin
            wptr <= wptr - 1'b1;
          end
          if (!zero_r) begin
            if (sep_now) begin
              th <= '0;
            end else begin
              if (grp_en) begin
                th <= th + 3'd1;
              end
              rem <= rem_dec;
            end
          end
        end
        ST_SIGN: begin
          if (mem_we) begin
            wptr <= wptr - 1'b1;
          end
        end
        ST_PRIME: begin
          raddr <= wptr;
        end
        ST_EMIT: begin
          if (out_load && !emit_last) begin
            raddr <= raddr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // digit shift register and sign flags, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      digs   <= DIG_W'(mag_in);
      zero_r <= (mag_in == '0);
      neg_r  <= neg_in;
    end else if (state == ST_CONV && dab_done) begin
      digs <= dab_bcd;
    end else if (state == ST_GEN && !zero_r && !sep_now) begin
      digs <= digs_shift;
    end
  end

  // --------------------------------------------------------------------------
  // output register, one beat per character
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_load) begin
      char_code <= mem_rdata;
      last_char <= emit_last;
    end
  end

  // --------------------------------------------------------------------------
  // submodules
  // --------------------------------------------------------------------------
  i2a_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .value (mag_in),
    .bcd   (dab_bcd),
    .done  (dab_done)
  );

  i2a_charbuf u_charbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
